[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/bve_pkg.sv]
// Command and status codes of the byte vector engine.
package bve_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_ASSIGN = 3'd1,
        ACT_POP    = 3'd2,
        ACT_ERASE  = 3'd3,
        ACT_GET    = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam int DATA_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int LENGTH_W = 9;

endpackage

[rtl/core/bve_ram.sv]
// Element memory: one write port, one read port, registered read data.
module bve_ram #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [bve_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [bve_pkg::DATA_W-1:0] o_rdata
);
    import bve_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/byte_vector_engine.sv]
// Top level of the byte vector engine: command sequencer around the element memory.
//
// Holds an ordered sequence of up to DEPTH bytes and its length. Commands arrive on
// the input channel (i_in_valid / o_in_ready; fields i_action, i_index, i_data), one
// transaction each, and every command yields exactly one result transaction on the
// output channel (o_out_valid / i_out_ready; o_read_data, o_status, o_length).
// Push, assign, pop, get and clear: the accept cycle issues the memory read at the
// requested index, the next cycle checks the length, writes the memory and loads
// the result register. Erase at index k with n elements, k below n - 1, then runs a
// shift loop: after the first read the sequencer moves one element per cycle down
// by one place, reading ahead of the write through the memory's single read and
// single write port. That erase loop sets the worst-case rate.
// The result is registered into the output register as the last working cycle ends.
// A new command is taken while an earlier result still waits: if the output
// register is still full when the next result is ready, that result parks in a
// holding register and the engine stops taking commands until the output drains.
// Synchronous active-low reset empties the sequence (length zero) and drops any
// pending result; the memory contents are not cleared, since only bytes at positions
// below the length are ever used and each of those was written first.
module byte_vector_engine #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_index,
    input  logic [7:0] i_data,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status,
    output logic [8:0] o_length
);
    import bve_pkg::*;

    `include "assert_macros.svh"

    // common width for comparing an index against the length
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_action;
    logic [INDEX_W-1:0] r_index;
    logic [DATA_W-1:0] r_data;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_ptr, n_ptr;

    // output register and holding register
    logic                r_o_valid;
    logic [DATA_W-1:0]   r_o_read_data;
    t_status             r_o_status;
    logic [LENGTH_W-1:0] r_o_length;
    logic [DATA_W-1:0]   r_p_read_data;
    t_status             r_p_status;
    logic [LENGTH_W-1:0] r_p_length;

    // memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // result of the command finishing this cycle
    logic                fin;
    logic [DATA_W-1:0]   res_read_data;
    t_status             res_status;
    logic [LENGTH_W-1:0] res_length;

    logic          in_acc;
    logic          out_free;
    logic          empty;
    logic          full;
    logic          idx_ge;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] idx_next;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(DEPTH));
    assign idx_x    = XW'(r_index);
    assign cnt_x    = XW'(r_count);
    assign idx_ge   = (idx_x >= cnt_x);
    assign idx_next = idx_x + XW'(1);

    bve_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        ram_we        = 1'b0;
        ram_waddr     = AW'(r_count);
        ram_wdata     = r_data;
        ram_raddr     = AW'(i_index);
        fin           = 1'b0;
        res_read_data = '0;
        res_status    = ST_OK;

        case (r_state)
            S_IDLE: begin
                // read at the incoming index so a get has its byte next cycle
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                case (t_action'(r_action))
                    ACT_PUSH: begin
                        if (full) begin
                            res_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            n_count   = r_count + CW'(1);
                        end
                    end
                    ACT_ASSIGN: begin
                        // past the end: overwrite the last element
                        if (empty) begin
                            res_status = ST_EMPTY;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_ge ? AW'(r_count - CW'(1)) : AW'(r_index);
                        end
                    end
                    ACT_POP: begin
                        if (empty) begin
                            res_status = ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    ACT_ERASE: begin
                        if (empty) begin
                            res_status = ST_EMPTY;
                        end else if (idx_ge) begin
                            res_status = ST_RANGE;
                        end else if (idx_next < cnt_x) begin
                            // elements follow: start the shift loop
                            fin       = 1'b0;
                            ram_raddr = AW'(idx_next);
                            n_ptr     = AW'(idx_next);
                            n_state   = S_SHIFT;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    ACT_GET: begin
                        if (empty) begin
                            res_status = ST_EMPTY;
                        end else if (idx_ge) begin
                            res_status = ST_RANGE;
                        end else begin
                            res_read_data = ram_rdata;
                        end
                    end
                    ACT_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        // unused codes: no change
                    end
                endcase
            end
            S_SHIFT: begin
                // move element r_ptr down one place, fetch the next one
                ram_we    = 1'b1;
                ram_waddr = r_ptr - AW'(1);
                ram_wdata = ram_rdata;
                if ((CW'(r_ptr) + CW'(1)) < r_count) begin
                    ram_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end else begin
                    fin     = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res_length = LENGTH_W'(n_count);

        if (fin) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;

            if (in_acc) begin
                r_action <= i_action;
                r_index  <= i_index;
                r_data   <= i_data;
            end

            // load the output from the holding register or straight from the result
            if (r_state == S_HOLD && out_free) begin
                r_o_valid     <= 1'b1;
                r_o_read_data <= r_p_read_data;
                r_o_status    <= r_p_status;
                r_o_length    <= r_p_length;
            end else if (fin && out_free) begin
                r_o_valid     <= 1'b1;
                r_o_read_data <= res_read_data;
                r_o_status    <= res_status;
                r_o_length    <= res_length;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            // park the result while the output register is still occupied
            if (fin && !out_free) begin
                r_p_read_data <= res_read_data;
                r_p_status    <= res_status;
                r_p_length    <= res_length;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_read_data = r_o_read_data;
    assign o_status    = r_o_status;
    assign o_length    = r_o_length;

    // length never exceeds the capacity
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "length above DEPTH")

    // a parked result only exists while the output register is occupied
    `ASSERT_IMPLY(a_hold_busy, i_clk, i_rst_n, r_state == S_HOLD, r_o_valid, "hold without output")

    // the shift pointer stays inside the held elements
    `ASSERT_IMPLY(a_shift_ptr, i_clk, i_rst_n, r_state == S_SHIFT,
        (CW'(r_ptr) < r_count) && (r_ptr != '0), "shift pointer out of range")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the byte vector engine: random and directed commands.
`timescale 1ns / 100ps

module testbench;
    import bve_pkg::*;

    localparam int VEC_DEPTH      = 256;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_CMDS    = 450;
    // A full-length erase moves up to DEPTH - 1 elements, so let that much settle.
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 600_000;

    // Action codes outside the enum; the engine must ignore them.
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    // One queued command. A pause marker holds the sender until all results are back.
    typedef struct packed {
        logic                 pause_mark;
        logic [2:0]           act;
        logic [INDEX_W-1:0]   idx;
        logic [DATA_W-1:0]    dat;
    } t_vec_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]    rd;
        t_status              st;
        logic [LENGTH_W-1:0]  len;
    } t_vec_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [2:0]          i_action    = '0;
    logic [7:0]          i_index     = '0;
    logic [7:0]          i_data      = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [7:0]          o_read_data;
    logic [1:0]          o_status;
    logic [8:0]          o_length;

    byte_vector_engine #(
        .DEPTH (VEC_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_data      (i_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .o_status    (o_status),
        .o_length    (o_length)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow vector: the expected contents and length of the engine.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] vec_bytes [0:VEC_DEPTH-1];
    int unsigned       vec_count = 0;

    t_vec_cmd          pending_cmds[$];
    t_vec_result       expected_results[$];
    int unsigned       mismatches   = 0;
    int unsigned       result_count = 0;
    logic              cmd_taken    = 1'b0;

    // Apply one command to the shadow vector and return the result it must produce.
    function automatic t_vec_result apply_command(t_vec_cmd c);
        t_vec_result r;
        int unsigned pos;
        r.rd = '0;
        r.st = ST_OK;
        case (c.act)
            ACT_PUSH: begin
                if (vec_count >= VEC_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    vec_bytes[vec_count] = c.dat;
                    vec_count++;
                end
            end
            ACT_ASSIGN: begin
                if (vec_count == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    // past the end lands on the last element
                    pos = (c.idx >= vec_count) ? vec_count - 1 : c.idx;
                    vec_bytes[pos] = c.dat;
                end
            end
            ACT_POP: begin
                if (vec_count == 0) r.st = ST_EMPTY;
                else vec_count--;
            end
            ACT_ERASE: begin
                if (vec_count == 0) begin
                    r.st = ST_EMPTY;
                end else if (c.idx >= vec_count) begin
                    r.st = ST_RANGE;
                end else begin
                    // close the gap: shift the tail down by one place
                    for (pos = c.idx; pos + 1 < vec_count; pos++)
                        vec_bytes[pos] = vec_bytes[pos + 1];
                    vec_count--;
                end
            end
            ACT_GET: begin
                if (vec_count == 0) r.st = ST_EMPTY;
                else if (c.idx >= vec_count) r.st = ST_RANGE;
                else r.rd = vec_bytes[c.idx];
            end
            ACT_CLEAR: vec_count = 0;
            default: ;
        endcase
        r.len = LENGTH_W'(vec_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation. gen_len tracks the length the queued commands
    // will leave behind, so indices can be steered into the live range.
    // ------------------------------------------------------------------
    int unsigned gen_len   = 0;
    int unsigned gen_count = 0;

    task automatic add_cmd(input logic [2:0] act, input logic [7:0] idx, input logic [7:0] dat);
        t_vec_cmd c;
        c.pause_mark = 1'b0;
        c.act        = act;
        c.idx        = idx;
        c.dat        = dat;
        pending_cmds = {pending_cmds, c};
        case (act)
            ACT_PUSH:  if (gen_len < VEC_DEPTH) gen_len++;
            ACT_POP:   if (gen_len > 0) gen_len--;
            ACT_ERASE: if (idx < gen_len) gen_len--;
            ACT_CLEAR: gen_len = 0;
            default: ;
        endcase
        // ignored codes do not count toward the stimulus budget
        if (act != ACT_RSVD6 && act != ACT_RSVD7) gen_count++;
    endtask

    task automatic add_pause();
        t_vec_cmd c;
        c = '0;
        c.pause_mark = 1'b1;
        pending_cmds = {pending_cmds, c};
    endtask

    // Mostly a live position, sometimes anything the field can hold.
    function automatic logic [7:0] pick_index();
        if (gen_len > 0 && $urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, gen_len - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] pick_action(int unsigned push_pct, bit allow_clear);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return ACT_PUSH;
        r = $urandom_range(0, 99);
        if (r < 22) return ACT_ASSIGN;
        if (r < 40) return ACT_POP;
        if (r < 60) return ACT_ERASE;
        if (r < 88) return ACT_GET;
        if (r < 94) return allow_clear ? ACT_CLEAR : ACT_GET;
        if (r < 97) return ACT_RSVD6;
        return ACT_RSVD7;
    endfunction

    task automatic add_random(input int unsigned push_pct, input bit allow_clear);
        logic [2:0] act;
        act = pick_action(push_pct, allow_clear);
        add_cmd(act, pick_index(), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. Drive on
    // the falling edge; hold valid and payload until the transaction is taken.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin : drive_cmds
        t_vec_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || cmd_taken) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_cmds.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_cmds[0].pause_mark) begin
                // hold off until the engine has answered everything
                i_in_valid <= 1'b0;
                if (expected_results.size() == 0) void'(pending_cmds.pop_front());
            end else begin
                c = pending_cmds.pop_front();
                i_action   <= c.act;
                i_index    <= c.idx;
                i_data     <= c.dat;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 32);
                    gap_left   <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode that is re-drawn at random intervals.
    // Twice in the run, hold ready low for a long stretch so the engine's
    // output and holding registers fill and it stalls the command channel.
    // ------------------------------------------------------------------
    int unsigned hold_left     = 0;
    int unsigned hold_armed_at = 0;
    int unsigned mode_left     = 0;
    int unsigned rx_mode       = 0;
    logic        rx_flip       = 1'b0;

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if ((result_count == 120 || result_count == 330)
                     && hold_armed_at != result_count) begin
            i_out_ready   <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_armed_at <= result_count;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            rx_flip <= ~rx_flip;
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 99) < 70);
                2:       i_out_ready <= ($urandom_range(0, 99) < 25);
                default: i_out_ready <= rx_flip;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge. Check the result side first so a
    // command taken at the same edge never pairs with an older result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_vec_result want;
        t_vec_cmd    c;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: read_data %02h status %0d length %0d",
                             $time, o_read_data, o_status, o_length);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_data !== want.rd) begin
                        $display("%0t: read_data expected %02h, got %02h",
                                 $time, want.rd, o_read_data);
                        mismatches++;
                    end
                    if (o_status !== want.st) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.st, o_status);
                        mismatches++;
                    end
                    if (o_length !== want.len) begin
                        $display("%0t: length expected %0d, got %0d",
                                 $time, want.len, o_length);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                c.pause_mark = 1'b0;
                c.act        = i_action;
                c.idx        = i_index;
                c.dat        = i_data;
                expected_results = {expected_results, apply_command(c)};
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the command list, reset, wait for the drain.
    // ------------------------------------------------------------------
    initial begin
        int unsigned base_count;

        // Directed: every action on an empty vector, field extremes, past-end
        // assign, out-of-range get and erase, ignored codes, clear when empty.
        add_cmd(ACT_GET,    8'h00, 8'h00);
        add_cmd(ACT_POP,    8'h00, 8'h00);
        add_cmd(ACT_ERASE,  8'h00, 8'h00);
        add_cmd(ACT_ASSIGN, 8'hFF, 8'hFF);
        add_cmd(ACT_CLEAR,  8'h00, 8'h00);
        add_cmd(ACT_PUSH,   8'h00, 8'h00);
        add_cmd(ACT_PUSH,   8'hFF, 8'hFF);
        add_cmd(ACT_PUSH,   8'h00, 8'hA5);
        add_cmd(ACT_ASSIGN, 8'h01, 8'h5A);
        add_cmd(ACT_ASSIGN, 8'hFF, 8'h3C);
        add_cmd(ACT_GET,    8'h00, 8'hFF);
        add_cmd(ACT_GET,    8'h01, 8'h00);
        add_cmd(ACT_GET,    8'h02, 8'h00);
        add_cmd(ACT_GET,    8'h03, 8'h00);
        add_cmd(ACT_GET,    8'hFF, 8'h00);
        add_cmd(ACT_ERASE,  8'h05, 8'h00);
        add_cmd(ACT_ERASE,  8'h00, 8'h00);
        add_cmd(ACT_GET,    8'h00, 8'h00);
        add_cmd(ACT_POP,    8'h00, 8'h00);
        add_cmd(ACT_RSVD6,  8'hFF, 8'hFF);
        add_cmd(ACT_RSVD7,  8'h00, 8'h00);
        add_cmd(ACT_CLEAR,  8'h00, 8'h00);
        add_cmd(ACT_GET,    8'h00, 8'h00);
        add_pause();

        base_count = gen_count;

        // Mixed traffic at short lengths.
        repeat (70) add_random(40, 1'b1);
        add_pause();

        // Fill to capacity, then push into a full vector and erase the head,
        // which forces the longest shift.
        while (gen_len < VEC_DEPTH) add_random(92, 1'b0);
        repeat (3) add_cmd(ACT_PUSH, pick_index(), 8'($urandom));
        add_cmd(ACT_GET,    8'hFF, 8'($urandom));
        add_cmd(ACT_ASSIGN, 8'hFF, 8'($urandom));
        add_cmd(ACT_ERASE,  8'h00, 8'($urandom));
        repeat (2) add_cmd(ACT_PUSH, pick_index(), 8'($urandom));

        // Churn at high length, then clear and go back to mixed traffic.
        repeat (40) add_random(30, 1'b0);
        add_cmd(ACT_CLEAR, pick_index(), 8'($urandom));
        while (gen_count - base_count < RANDOM_CMDS) add_random(45, 1'b1);

        // Drain to empty with pops and erases, then poke the empty vector.
        while (gen_len > 0) begin
            if ($urandom_range(0, 1) == 0) add_cmd(ACT_POP, pick_index(), 8'($urandom));
            else add_cmd(ACT_ERASE, pick_index(), 8'($urandom));
        end
        add_cmd(ACT_ASSIGN, pick_index(), 8'($urandom));
        add_cmd(ACT_GET,    pick_index(), 8'($urandom));
        add_cmd(ACT_ERASE,  pick_index(), 8'($urandom));
        add_cmd(ACT_POP,    pick_index(), 8'($urandom));

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
